// ----- design/vlats_pkg.sv -----
// ----------------------------------------------------------------------------
// vlats_pkg: shared types, constants and tables of the angle-table shader
// Holds the CORDIC angle table, fixed-point constants and the cell bundle.
// ----------------------------------------------------------------------------
`default_nettype none
package vlats_pkg;

   localparam int GridSteps  = 256;
   localparam int GridBits   = $clog2(GridSteps);
   localparam int Iters      = 14;
   localparam int InvGainQ16 = 39797;
   localparam int StaticScale = 16256;
   localparam int StaticMin  = 12800;
   localparam int LevelMax   = 65536;

   // wide datapath for the CORDIC cells
   localparam int DW = 40;
   typedef logic signed [DW-1:0] dval_type;

   localparam logic signed [DW-1:0] InvGainQ30 = 40'sd652032874;

   function automatic logic signed [16:0] atan_turn(input int i);
      logic signed [16:0] r;
      begin
         unique case (i)
            0: r = 17'sd8192;
            1: r = 17'sd4836;
            2: r = 17'sd2555;
            3: r = 17'sd1297;
            4: r = 17'sd651;
            5: r = 17'sd326;
            6: r = 17'sd163;
            7: r = 17'sd81;
            8: r = 17'sd41;
            9: r = 17'sd20;
            10: r = 17'sd10;
            11: r = 17'sd5;
            12: r = 17'sd3;
            13: r = 17'sd1;
            default: r = 17'sd0;
         endcase
         return r;
      end
   endfunction

   // one CORDIC word: x, y, angle accumulator
   typedef struct packed {
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic signed [17:0]   a;
   } cword_type;

endpackage
`default_nettype wire

// ----- design/vertex_light_angle_table_shade_core.sv -----
// ----------------------------------------------------------------------------
// vertex_light_angle_table_shade_core: vertex light factor from an angle grid
// Normal to yaw/elevation by CORDIC vectoring, grid quantize, CORDIC rebuild,
// dot with the light direction and clamp to a Q1.16 light level.
// ----------------------------------------------------------------------------
//  channel | ports                         | direction
//  req     | req_valid/req_stall + fields  | in
//  rsp     | rsp_valid/rsp_stall + level   | out
//
//  one word per cycle while the rsp side keeps up; from accept to rsp_valid a word
//  passes two 14-cell vectoring chains, two 14-cell rotation chains side by side,
//  ten setup/product stages and the output register.
//  the whole pipeline advances when the output stage is empty or taken, so
//  a new word enters every cycle while the rsp side keeps up.
//  reset clears the stage valid bits only.
`default_nettype none
module vertex_light_angle_table_shade_core import vlats_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_normal_x,
   input  wire logic signed [15:0] req_normal_y,
   input  wire logic signed [15:0] req_normal_z,
   input  wire logic signed [15:0] req_light_dir_x,
   input  wire logic signed [15:0] req_light_dir_y,
   input  wire logic signed [15:0] req_light_dir_z,
   input  wire logic signed [15:0] req_pitch_offset,
   input  wire logic signed [15:0] req_yaw_offset,
   input  wire logic               req_dynamic_light,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [16:0]             rsp_light_level
);
   localparam int NS = 3*Iters + 10;

   // side data that rides along the chain
   typedef struct packed {
      logic signed [15:0] nz, lx, ly, lz, po, yo;
      logic               dyn, vert;
      logic [15:0]        elev_v;
   } side_type;

   logic adv;
   logic [NS-1:0] v_ff;
   side_type      s_ff [NS];

   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // valid shift line and side data
   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[NS-2:0], req_valid};
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff[0] <= '{req_normal_z, req_light_dir_x, req_light_dir_y, req_light_dir_z,
                     req_pitch_offset, req_yaw_offset, req_dynamic_light,
                     (req_normal_x == 0) && (req_normal_y == 0),
                     (req_normal_z > 0) ? 16'd16384 : 16'd49152};
         for (int i = 1; i < NS; i++) s_ff[i] <= s_ff[i-1];
      end
   end

   // stage 0: yaw vectoring setup (pre-rotation for negative x)
   cword_type y0_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         if (req_normal_x < 0) begin
            y0_ff.x <= -(DW'(req_normal_x) <<< 16);
            y0_ff.y <= -(DW'(req_normal_y) <<< 16);
            y0_ff.a <= 18'sd32768;
         end else begin
            y0_ff.x <= DW'(req_normal_x) <<< 16;
            y0_ff.y <= DW'(req_normal_y) <<< 16;
            y0_ff.a <= '0;
         end
      end
   end

   // yaw vectoring chain
   cword_type ych [Iters+1];
   assign ych[0] = y0_ff;
   for (genvar i = 0; i < Iters; i++) begin : g_yaw
      vlats_vec_cell u_c (.clock, .adv, .shift(4'(i)), .d_in(ych[i]), .d_out(ych[i+1]));
   end

   // horizontal length product, then rounding and elevation setup
   logic signed [55:0] mag_ff;
   logic [15:0] yaw_a_ff, yaw_b_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff   <= 56'(ych[Iters].x) * 56'(InvGainQ16);
         yaw_a_ff <= ych[Iters].a[15:0];
      end
   end
   cword_type e0_ff;
   logic signed [DW-1:0] fwd;
   assign fwd = DW'((mag_ff + 56'sd32768) >>> 16);
   always_ff @(posedge clock) begin
      if (adv) begin
         yaw_b_ff <= yaw_a_ff;
         if (fwd < 0) begin
            e0_ff.x <= -fwd;
            e0_ff.y <= -(DW'(s_ff[Iters+1].nz) <<< 16);
            e0_ff.a <= 18'sd32768;
         end else begin
            e0_ff.x <= fwd;
            e0_ff.y <= DW'(s_ff[Iters+1].nz) <<< 16;
            e0_ff.a <= '0;
         end
      end
   end

   // elevation vectoring chain, yaw rides along
   cword_type ech [Iters+1];
   logic [15:0] yaw_d_ff [Iters];
   assign ech[0] = e0_ff;
   for (genvar i = 0; i < Iters; i++) begin : g_elev
      vlats_vec_cell u_c (.clock, .adv, .shift(4'(i)), .d_in(ech[i]), .d_out(ech[i+1]));
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         yaw_d_ff[0] <= yaw_b_ff;
         for (int i = 1; i < Iters; i++) yaw_d_ff[i] <= yaw_d_ff[i-1];
      end
   end

   // sums, quantize, grid angles, quadrant fold; two angles go through two
   // rotation chains side by side
   localparam int SQ = 2*Iters + 2;  // side index aligned with ech[Iters]
   side_type sq;
   logic [15:0] yaw_q, elev_q, psum, ysum, pang, yang;
   assign sq = s_ff[SQ];
   always_comb begin
      yaw_q  = sq.vert ? 16'd0 : yaw_d_ff[Iters-1];
      elev_q = sq.vert ? sq.elev_v : ech[Iters].a[15:0];
      psum = elev_q + sq.po;
      ysum = yaw_q + sq.yo;
      pang = {psum[15 -: GridBits], {(16-GridBits){1'b0}}};
      yang = {ysum[15 -: GridBits], {(16-GridBits){1'b0}}};
   end

   function automatic cword_type rot_setup(input logic [15:0] ang, output logic neg);
      cword_type w;
      logic signed [17:0] z;
      begin
         z = 18'(signed'(ang));
         neg = 1'b0;
         if (z > 18'sd16384) begin
            z = z - 18'sd32768; neg = 1'b1;
         end else if (z < -18'sd16384) begin
            z = z + 18'sd32768; neg = 1'b1;
         end
         w.x = InvGainQ30;
         w.y = '0;
         w.a = z;
         return w;
      end
   endfunction

   cword_type pa0_ff, ya0_ff;
   logic pneg_ff, yneg_ff;
   always_ff @(posedge clock) begin
      logic pn, yn;
      if (adv) begin
         pa0_ff <= rot_setup(pang, pn);
         ya0_ff <= rot_setup(yang, yn);
         pneg_ff <= pn;
         yneg_ff <= yn;
      end
   end

   cword_type pch [Iters+1], ych2 [Iters+1];
   logic [Iters-1:0] pneg_d_ff, yneg_d_ff;
   assign pch[0] = pa0_ff;
   assign ych2[0] = ya0_ff;
   for (genvar i = 0; i < Iters; i++) begin : g_rot
      vlats_rot_cell u_p (.clock, .adv, .shift(4'(i)), .d_in(pch[i]), .d_out(pch[i+1]));
      vlats_rot_cell u_y (.clock, .adv, .shift(4'(i)), .d_in(ych2[i]), .d_out(ych2[i+1]));
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         pneg_d_ff <= {pneg_d_ff[Iters-2:0], pneg_ff};
         yneg_d_ff <= {yneg_d_ff[Iters-2:0], yneg_ff};
      end
   end

   // round cos/sin to Q14
   logic signed [DW-1:0] px, py, yx, yy;
   logic signed [15:0] ca_ff, sa_ff, cb_ff, sb_ff;
   always_comb begin
      px = pneg_d_ff[Iters-1] ? -pch[Iters].x  : pch[Iters].x;
      py = pneg_d_ff[Iters-1] ? -pch[Iters].y  : pch[Iters].y;
      yx = yneg_d_ff[Iters-1] ? -ych2[Iters].x : ych2[Iters].x;
      yy = yneg_d_ff[Iters-1] ? -ych2[Iters].y : ych2[Iters].y;
   end
   always_ff @(posedge clock) begin
      logic signed [DW-1:0] t0, t1, t2, t3;
      if (adv) begin
         t0 = (px + DW'(32768)) >>> 16;
         t1 = (py + DW'(32768)) >>> 16;
         t2 = (yx + DW'(32768)) >>> 16;
         t3 = (yy + DW'(32768)) >>> 16;
         ca_ff <= t0[15:0];
         sa_ff <= t1[15:0];
         cb_ff <= t2[15:0];
         sb_ff <= t3[15:0];
      end
   end

   // direction products
   localparam int SD = 3*Iters + 6;
   logic signed [31:0] pxa_ff, pya_ff;
   logic signed [15:0] vz_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         pxa_ff <= cb_ff * ca_ff;
         pya_ff <= cb_ff * sa_ff;
         vz_ff  <= -sb_ff;
      end
   end
   logic signed [15:0] vx_ff, vy_ff, vz2_ff;
   always_ff @(posedge clock) begin
      logic signed [31:0] a, b;
      if (adv) begin
         a = (pxa_ff + 32'sd8192) >>> 14;
         b = (pya_ff + 32'sd8192) >>> 14;
         vx_ff <= a[15:0];
         vy_ff <= b[15:0];
         vz2_ff <= vz_ff;
      end
   end

   // dot product terms, then sum
   side_type sd;
   assign sd = s_ff[SD];
   logic signed [31:0] tx_ff, ty_ff, tz_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         tx_ff <= vx_ff * sd.lx;
         ty_ff <= vy_ff * sd.ly;
         tz_ff <= vz2_ff * sd.lz;
      end
   end
   logic signed [33:0] dot_ff;
   always_ff @(posedge clock) begin
      if (adv) dot_ff <= 34'(tx_ff) + 34'(ty_ff) + 34'(tz_ff);
   end

   // static scale product
   side_type se;
   assign se = s_ff[SD+2];
   logic signed [49:0] sc_ff;
   logic signed [33:0] dot2_ff;
   logic dyn_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         sc_ff   <= (50'(dot_ff) + (50'sd1 <<< 29)) * 50'sd16256;
         dot2_ff <= dot_ff;
         dyn_ff  <= se.dyn;
      end
   end

   // clamp and output register
   logic [16:0] lvl;
   always_comb begin
      logic signed [49:0] v;
      if (dyn_ff) begin
         v = (50'(dot2_ff) + 50'sd2048) >>> 12;
         if (dot2_ff <= 0) v = '0;
         if (v > 50'sd65536) v = 50'sd65536;
      end else begin
         v = (sc_ff + (50'sd1 <<< 27)) >>> 28;
         if (v < 50'sd12800) v = 50'sd12800;
         if (v > 50'sd65536) v = 50'sd65536;
      end
      lvl = v[16:0];
   end
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (adv) rsp_valid <= v_ff[NS-1];
   end
   always_ff @(posedge clock) begin
      if (adv) rsp_light_level <= lvl;
   end
endmodule
`default_nettype wire

// ----- design/vlats_vec_cell.sv -----
// ----------------------------------------------------------------------------
// vlats_vec_cell: one CORDIC vectoring iteration, registered
// Drives y toward zero and accumulates the turned angle.
// ----------------------------------------------------------------------------
`default_nettype none
module vlats_vec_cell import vlats_pkg::*; (
   input  wire logic      clock,
   input  wire logic      adv,
   input  wire logic [3:0] shift,
   input  wire cword_type d_in,
   output cword_type      d_out
);
   cword_type d_ff, d_in_c;
   logic signed [DW-1:0] dx, dy;

   // rotate one step
   always_comb begin
      dx = d_in.x >>> shift;
      dy = d_in.y >>> shift;
      if (d_in.y >= 0) begin
         d_in_c.x = d_in.x + dy;
         d_in_c.y = d_in.y - dx;
         d_in_c.a = d_in.a + 18'(atan_turn(int'(shift)));
      end else begin
         d_in_c.x = d_in.x - dy;
         d_in_c.y = d_in.y + dx;
         d_in_c.a = d_in.a - 18'(atan_turn(int'(shift)));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) d_ff <= d_in_c;
   end
   assign d_out = d_ff;
endmodule
`default_nettype wire

// ----- design/vlats_rot_cell.sv -----
// ----------------------------------------------------------------------------
// vlats_rot_cell: one CORDIC rotation iteration, registered
// Drives the residual angle toward zero while turning the vector.
// ----------------------------------------------------------------------------
`default_nettype none
module vlats_rot_cell import vlats_pkg::*; (
   input  wire logic      clock,
   input  wire logic      adv,
   input  wire logic [3:0] shift,
   input  wire cword_type d_in,
   output cword_type      d_out
);
   cword_type d_ff, d_in_c;
   logic signed [DW-1:0] dx, dy;

   // rotate one step
   always_comb begin
      dx = d_in.x >>> shift;
      dy = d_in.y >>> shift;
      if (d_in.a >= 0) begin
         d_in_c.x = d_in.x - dy;
         d_in_c.y = d_in.y + dx;
         d_in_c.a = d_in.a - 18'(atan_turn(int'(shift)));
      end else begin
         d_in_c.x = d_in.x + dy;
         d_in_c.y = d_in.y - dx;
         d_in_c.a = d_in.a + 18'(atan_turn(int'(shift)));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) d_ff <= d_in_c;
   end
   assign d_out = d_ff;
endmodule
`default_nettype wire

// ----- tb/sv/vertex_light_angle_table_shade_core_test.sv -----
// ----------------------------------------------------------------------------
// vertex_light_angle_table_shade_core_test: self-checking bench of the shader
// Drives normals, light directions and offsets, predicts each light level
// with an independent fixed-point model and checks words in order.
// ----------------------------------------------------------------------------
`default_nettype none

// in-order store of predicted light levels
class level_board_type;
   logic [16:0] pending[$];
   int          errors;

   function new();
      errors = 0;
   endfunction

   function void note(logic [16:0] lvl);
      pending.push_back(lvl);
   endfunction

   function void check(logic [16:0] got, longint t);
      logic [16:0] want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected word, expected none, actual %0d", t, got);
         errors++;
      end else begin
         want = pending.pop_front();
         if (want !== got) begin
            $display("%0t: light_level mismatch, expected %0d, actual %0d", t, want, got);
            errors++;
         end
      end
   endfunction
endclass

module vertex_light_angle_table_shade_core_test import vlats_pkg::*; ;

   localparam int WatchLimit = 4000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [15:0] req_normal_x = 0, req_normal_y = 0, req_normal_z = 0;
   logic signed [15:0] req_light_dir_x = 0, req_light_dir_y = 0, req_light_dir_z = 0;
   logic signed [15:0] req_pitch_offset = 0, req_yaw_offset = 0;
   logic req_dynamic_light = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [16:0] rsp_light_level;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles = 0;
   bit timed_out = 0;
   level_board_type board;

   vertex_light_angle_table_shade_core dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // arithmetic shift right with floor, as the datapath rounds
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint turn_atan(int i);
      return longint'(atan_turn(i));
   endfunction

   // vectoring: angle of (x, y) in 1/65536 turn and gain-scaled length
   function automatic logic [15:0] vector_angle(longint x, longint y, output longint mag);
      longint a, dx, dy;
      a = 0;
      if (x < 0) begin
         x = -x; y = -y; a = 32768;
      end
      for (int i = 0; i < Iters; i++) begin
         dx = floor_shift(x, i);
         dy = floor_shift(y, i);
         if (y >= 0) begin
            x += dy; y -= dx; a += turn_atan(i);
         end else begin
            x -= dy; y += dx; a -= turn_atan(i);
         end
      end
      mag = x;
      return a[15:0];
   endfunction

   // rotation: Q14 cosine and sine of an angle
   function automatic void rotate_angle(logic [15:0] ang, output longint c, output longint s);
      longint z, x, y, dx, dy;
      bit flip;
      z = ang;
      x = 652032874;
      y = 0;
      flip = 0;
      if (z >= 32768) z -= 65536;
      if (z > 16384) begin
         z -= 32768; flip = 1;
      end else if (z < -16384) begin
         z += 32768; flip = 1;
      end
      for (int i = 0; i < Iters; i++) begin
         dx = floor_shift(x, i);
         dy = floor_shift(y, i);
         if (z >= 0) begin
            x -= dy; y += dx; z -= turn_atan(i);
         end else begin
            x += dy; y -= dx; z += turn_atan(i);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = floor_shift(x + 32768, 16);
      s = floor_shift(y + 32768, 16);
   endfunction

   function automatic logic [16:0] shade_level(
      logic signed [15:0] nx, logic signed [15:0] ny, logic signed [15:0] nz,
      logic signed [15:0] lx, logic signed [15:0] ly, logic signed [15:0] lz,
      logic [15:0] pofs, logic [15:0] yofs, logic dyn);
      logic [15:0] yaw, elev, psum, ysum;
      longint r, fwd, pidx, yidx, ca, sa, cb, sb, vx, vy, vz, dot, v, t;
      if (nx == 0 && ny == 0) begin
         yaw = 0;
         elev = (nz > 0) ? 16'd16384 : 16'd49152;
      end else begin
         yaw = vector_angle(longint'(nx) * 65536, longint'(ny) * 65536, r);
         fwd = floor_shift(r * InvGainQ16 + 32768, 16);
         elev = vector_angle(fwd, longint'(nz) * 65536, r);
      end
      psum = elev + pofs;
      ysum = yaw + yofs;
      pidx = (longint'(psum) * GridSteps) >> 16;
      yidx = (longint'(ysum) * GridSteps) >> 16;
      rotate_angle(16'((pidx * 65536) / GridSteps), ca, sa);
      rotate_angle(16'((yidx * 65536) / GridSteps), cb, sb);
      vx = floor_shift(cb * ca + 8192, 14);
      vy = floor_shift(cb * sa + 8192, 14);
      vz = -sb;
      dot = vx * lx + vy * ly + vz * lz;
      if (dyn) begin
         v = (dot <= 0) ? 0 : (dot + 2048) >>> 12;
         if (v > LevelMax) v = LevelMax;
      end else begin
         t = dot + (longint'(1) << 29);
         v = (t <= 0) ? 0 : floor_shift(t * StaticScale + (longint'(1) << 27), 28);
         if (v < StaticMin) v = StaticMin;
         if (v > LevelMax) v = LevelMax;
      end
      return v[16:0];
   endfunction

   // offer one word, holding it until accepted
   task automatic send_word(logic signed [15:0] nx, logic signed [15:0] ny,
                            logic signed [15:0] nz, logic signed [15:0] lx,
                            logic signed [15:0] ly, logic signed [15:0] lz,
                            logic [15:0] pofs, logic [15:0] yofs, logic dyn);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_normal_x <= nx;
      req_normal_y <= ny;
      req_normal_z <= nz;
      req_light_dir_x <= lx;
      req_light_dir_y <= ly;
      req_light_dir_z <= lz;
      req_pitch_offset <= pofs;
      req_yaw_offset <= yofs;
      req_dynamic_light <= dyn;
      do @(posedge clock); while (req_stall);
      board.note(shade_level(nx, ny, nz, lx, ly, lz, pofs, yofs, dyn));
   endtask

   function automatic logic signed [15:0] pick_component();
      case ($urandom_range(9))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 0;
         3: return 16'($urandom);
         default: return 16'($urandom_range(32768)) - 16'sd16384;
      endcase
   endfunction

   task automatic send_random();
      logic signed [15:0] nx, ny;
      nx = pick_component();
      ny = pick_component();
      if ($urandom_range(7) == 0) begin
         nx = 0; ny = 0;
      end
      send_word(nx, ny, pick_component(), pick_component(), pick_component(),
                pick_component(), 16'($urandom), 16'($urandom), 1'($urandom));
   endtask

   // receiver stall and result check
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check(rsp_light_level, $time);
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      board = new();
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed: extremes, vertical normals, wrapping offsets, both light modes
      send_word(0, 0, 16384, 0, 0, 16384, 0, 0, 1);
      send_word(0, 0, -16384, 0, 0, -16384, 0, 0, 1);
      send_word(0, 0, 0, 16384, 16384, 16384, 0, 0, 0);
      send_word(0, 0, 16384, -16384, -16384, -16384, 0, 0, 0);
      send_word(16384, 0, 0, 16384, 0, 0, 0, 0, 1);
      send_word(-16384, 0, 0, -16384, 0, 0, 0, 0, 0);
      send_word(0, 16384, 0, 0, 16384, 0, 0, 0, 1);
      send_word(0, -16384, 0, 0, -16384, 0, 16'h8000, 16'h7fff, 1);
      send_word(16384, 16384, 16384, 16384, 16384, 16384, 16'hffff, 16'hffff, 1);
      send_word(-16384, -16384, -16384, -16384, -16384, -16384, 16'h8000, 16'h8000, 0);
      send_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                16'h7fff, 16'h7fff, 1);
      send_word(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000,
                16'h8000, 16'h8000, 0);
      send_word(1, -1, 1, 16'sh7fff, -16'sh8000, 16'sh7fff, 16'hffff, 1, 0);
      send_word(0, 0, 1, 0, 0, 16384, 16'hc000, 0, 0);
      send_word(0, 0, -1, 0, 0, 16384, 0, 16'h4000, 1);
      send_word(100, 0, 16384, 16384, 0, 0, 16'h00ff, 16'hff00, 1);

      // random: three idling phases
      for (int n = 0; n < 600; n++) begin
         if (n == 0) begin
            send_idle_pct = 16; recv_idle_pct = 57;
         end else if (n == 200) begin
            send_idle_pct = 57; recv_idle_pct = 16;
         end else if (n == 400) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         send_random();
      end
      req_valid <= 0;

      while (board.pending.size() != 0 && quiet_cycles < WatchLimit) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

`default_nettype wire

// ----- vertex_light_angle_table_shade_core.f -----
design/vlats_pkg.sv
design/vlats_vec_cell.sv
design/vlats_rot_cell.sv
design/vertex_light_angle_table_shade_core.sv
tb/sv/vertex_light_angle_table_shade_core_test.sv
